>>> rtl/core/dehpd_pkg.sv
// shared types, encoding codes and constants for the eh pointer decoder
package dehpd_pkg;

  localparam int POINTER_BYTES = 8;
  localparam int MAX_LEB_BYTES = 16;

  localparam int ENC_W   = 8;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 5;
  localparam int SHIFT_W = 7;

  localparam logic [7:0] ENC_OMIT  = 8'hFF;
  localparam logic [2:0] APP_PCREL = 3'd1;

  localparam logic [3:0] FORM_ABSPTR = 4'h0;
  localparam logic [3:0] FORM_ULEB   = 4'h1;
  localparam logic [3:0] FORM_UDATA2 = 4'h2;
  localparam logic [3:0] FORM_UDATA4 = 4'h3;
  localparam logic [3:0] FORM_UDATA8 = 4'h4;
  localparam logic [3:0] FORM_SLEB   = 4'h9;
  localparam logic [3:0] FORM_SDATA2 = 4'hA;
  localparam logic [3:0] FORM_SDATA4 = 4'hB;
  localparam logic [3:0] FORM_SDATA8 = 4'hC;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               field_start;
    logic [VALUE_W-1:0] field_address;
  } item_t;

  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] decoded_value;
    logic [COUNT_W-1:0] byte_count;
    logic               decode_error;
  } result_t;

endpackage

>>> rtl/core/dehpd_in_reg.sv
// input register stage holding one accepted byte beat
module dehpd_in_reg
  import dehpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tuser,
  input  logic        adv,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = in_tready ? in_tvalid : valid_r;
    item_nxt  = item_r;
    if (in_tready && in_tvalid) begin
      item_nxt.data_byte     = in_tdata[7:0];
      item_nxt.field_start   = in_tuser;
      item_nxt.field_address = in_tdata[71:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/core/dehpd_core.sv
// field state and single-pass decode of one byte
module dehpd_core
  import dehpd_pkg::*;
#(
  parameter int PTR_BYTES = POINTER_BYTES,
  parameter int LEB_BYTES = MAX_LEB_BYTES
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  item_t            item,
  input  logic [ENC_W-1:0] enc,
  output result_t          res
);

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] base_r, base_nxt;
  logic               in_field_r, in_field_nxt;

  logic [3:0]         form;
  logic               active;
  logic               supported;
  logic               is_leb;
  logic [COUNT_W-1:0] size;
  logic [VALUE_W-1:0] acc_e;
  logic [SHIFT_W-1:0] shift_e;
  logic [COUNT_W-1:0] cnt_e;
  logic [VALUE_W-1:0] base_e;
  logic [7:0]         lane;
  logic [VALUE_W-1:0] shifted;
  logic [VALUE_W-1:0] acc_new;
  logic [SHIFT_W:0]   shift_sum;
  logic [SHIFT_W-1:0] shift_new;
  logic [COUNT_W-1:0] cnt_new;
  logic [VALUE_W-1:0] fix_v;
  logic [VALUE_W-1:0] leb_v;
  logic [VALUE_W-1:0] val;

  assign form = enc[3:0];

  always_comb begin
    supported = 1'b1;
    is_leb    = 1'b0;
    size      = '0;
    unique case (form) inside
      FORM_ABSPTR:              size = COUNT_W'(PTR_BYTES);
      FORM_UDATA2, FORM_SDATA2: size = COUNT_W'(2);
      FORM_UDATA4, FORM_SDATA4: size = COUNT_W'(4);
      FORM_UDATA8, FORM_SDATA8: size = COUNT_W'(8);
      FORM_ULEB, FORM_SLEB:     is_leb = 1'b1;
      default:                  supported = 1'b0;
    endcase
  end

  always_comb begin
    active  = fire && (item.field_start || in_field_r);
    acc_e   = item.field_start ? '0 : acc_r;
    shift_e = item.field_start ? '0 : shift_r;
    cnt_e   = item.field_start ? '0 : cnt_r;
    base_e  = item.field_start ? item.field_address : base_r;

    lane    = is_leb ? {1'b0, item.data_byte[6:0]} : item.data_byte;
    shifted = shift_e[SHIFT_W-1] ? '0
                                 : ({{(VALUE_W-8){1'b0}}, lane} << shift_e[SHIFT_W-2:0]);
    acc_new = acc_e | shifted;

    shift_sum = {1'b0, shift_e} + (is_leb ? (SHIFT_W+1)'(7) : (SHIFT_W+1)'(8));
    shift_new = shift_sum[SHIFT_W] ? '1 : shift_sum[SHIFT_W-1:0];
    cnt_new   = cnt_e + COUNT_W'(1);

    // sign extension of the short fixed forms
    fix_v = acc_new;
    if (form == FORM_SDATA2 && acc_new[15]) begin
      fix_v[VALUE_W-1:16] = '1;
    end else if (form == FORM_SDATA4 && acc_new[31]) begin
      fix_v[VALUE_W-1:32] = '1;
    end

    leb_v = acc_new;
    if (form == FORM_SLEB && !shift_new[SHIFT_W-1] && item.data_byte[6]) begin
      leb_v = acc_new | ({VALUE_W{1'b1}} << shift_new[SHIFT_W-2:0]);
    end

    val = is_leb ? leb_v : fix_v;
    if (enc[6:4] == APP_PCREL) begin
      val = val + base_e;
    end
  end

  always_comb begin
    acc_nxt      = acc_r;
    shift_nxt    = shift_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    in_field_nxt = in_field_r;
    res          = '0;
    if (active) begin
      acc_nxt      = acc_e;
      shift_nxt    = shift_e;
      cnt_nxt      = cnt_e;
      base_nxt     = base_e;
      in_field_nxt = 1'b1;
      if (enc == ENC_OMIT) begin
        res.emit       = 1'b1;
        res.byte_count = COUNT_W'(1);
        in_field_nxt   = 1'b0;
      end else if (!supported) begin
        res.emit         = 1'b1;
        res.byte_count   = cnt_new;
        res.decode_error = 1'b1;
        in_field_nxt     = 1'b0;
      end else begin
        acc_nxt   = acc_new;
        shift_nxt = shift_new;
        cnt_nxt   = cnt_new;
        if (!is_leb) begin
          if (cnt_new >= size) begin
            res.emit          = 1'b1;
            res.decoded_value = val;
            res.byte_count    = cnt_new;
            in_field_nxt      = 1'b0;
          end
        end else if (item.data_byte[7]) begin
          if (cnt_new >= COUNT_W'(LEB_BYTES)) begin
            res.emit         = 1'b1;
            res.byte_count   = COUNT_W'(LEB_BYTES);
            res.decode_error = 1'b1;
            in_field_nxt     = 1'b0;
          end
        end else begin
          res.emit          = 1'b1;
          res.decoded_value = val;
          res.byte_count    = cnt_new;
          in_field_nxt      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      shift_r    <= '0;
      cnt_r      <= '0;
      base_r     <= '0;
      in_field_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      shift_r    <= shift_nxt;
      cnt_r      <= cnt_nxt;
      base_r     <= base_nxt;
      in_field_r <= in_field_nxt;
    end
  end

endmodule

>>> rtl/core/dehpd_out_reg.sv
// result register driving the output stream
module dehpd_out_reg
  import dehpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  result_t     res,
  output logic        adv,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic        out_tuser
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign adv = !valid_r || out_tready;

  always_comb begin
    valid_nxt = adv ? (fire && res.emit) : valid_r;
    res_nxt   = (fire && res.emit) ? res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.byte_count, res_r.decoded_value};
  assign out_tuser  = res_r.decode_error;

endmodule

>>> rtl/core/dwarf_eh_pointer_decoder.sv
// top level of the eh pointer encoded value decoder
//
//   channel   direction  payload
//   in_*      slave      tdata: data_byte, field_address   tuser: field_start
//   out_*     master     tdata: decoded_value, byte_count  tuser: decode_error
//   cfg_*     write      encoding_mode
//
// one byte beat per cycle while the output is not stalled: input register, one decode step, result register
// the field accumulator loop closes through shift, or and add
// rst_n clears handshake and field state, the encoding register reads zero
// an output stall holds the result and the input register backs up behind it
module dwarf_eh_pointer_decoder
  import dehpd_pkg::*;
#(
  parameter int PTR_BYTES = POINTER_BYTES,
  parameter int LEB_BYTES = MAX_LEB_BYTES
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [7:0] data_byte, [71:8] field_address
  input  logic        in_tuser,   // [0] field_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] decoded_value, [68:64] byte_count, zero pad
  output logic        out_tuser,  // [0] decode_error
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [ENC_W-1:0] enc_r, enc_nxt;
  logic             adv;
  logic             item_valid;
  logic             fire;
  item_t            item;
  result_t          res;

  assign enc_nxt = cfg_wr_en ? cfg_wr_data : enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= '0;
    end else begin
      enc_r <= enc_nxt;
    end
  end

  assign fire = item_valid && adv;

  dehpd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  dehpd_core #(
    .PTR_BYTES (PTR_BYTES),
    .LEB_BYTES (LEB_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .enc   (enc_r),
    .res   (res)
  );

  dehpd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/dehpd_checker.sv
// port-level checks on the result stream of the eh pointer decoder
module dehpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[68:64] != 5'd0 && out_tdata[68:64] <= 5'd16)
    else $error("byte count out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:0] == 64'd0)
    else $error("error beat carries a value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind dwarf_eh_pointer_decoder dehpd_checker u_dehpd_checker (.*);

>>> bench/tb_dwarf_eh_pointer_decoder.sv
// self-checking bench for the eh pointer decoder: random byte streams against a mirrored decoder
module tb_dwarf_eh_pointer_decoder;
  import dehpd_pkg::*;

  localparam int ITEM_TARGET   = 1800;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [3:0] FORM_RESERVED = 4'h5;

  typedef struct {
    logic [7:0]  data_byte;
    logic        field_start;
    logic [63:0] field_address;
  } byte_beat_t;

  typedef struct {
    logic [63:0] value;
    logic [4:0]  count;
    logic        err;
  } field_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // [7:0] data_byte, [71:8] field_address
  logic        in_tuser = 1'b0; // [0] field_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [63:0] decoded_value, [68:64] byte_count, zero pad
  logic        out_tuser;       // [0] decode_error
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  byte_beat_t    pending_bytes[$];
  field_result_t expected_fields[$];
  byte_beat_t    current_beat;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int cycle_count = 0;
  int fail_count = 0;

  int send_gap = 0;
  int send_stretch = 0;
  bit send_calm = 1'b0;
  int recv_stall = 0;
  int recv_stretch = 0;
  bit recv_calm = 1'b0;

  // decoder mirror
  logic [7:0]  dec_encoding = '0;
  logic [63:0] dec_acc = '0;
  int          dec_shift = 0;
  int          dec_seen = 0;
  logic [63:0] dec_base = '0;
  bit          dec_open = 1'b0;

  dwarf_eh_pointer_decoder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic close_field(logic [63:0] v, int n, logic e);
    field_result_t r;
    r.value = v;
    r.count = n[4:0];
    r.err   = e;
    expected_fields.insert(expected_fields.size(), r);
    dec_open = 1'b0;
  endtask

  task automatic decode_byte(byte_beat_t bt);
    logic [3:0]  form;
    int          size;
    logic [63:0] v;
    form = dec_encoding[3:0];
    size = 0;
    if (bt.field_start) begin
      dec_open  = 1'b1;
      dec_acc   = '0;
      dec_shift = 0;
      dec_seen  = 0;
      dec_base  = bt.field_address;
    end else if (!dec_open) begin
      return;
    end
    if (dec_encoding == ENC_OMIT) begin
      close_field('0, 1, 1'b0);
      return;
    end
    case (form)
      FORM_ABSPTR: size = POINTER_BYTES;
      FORM_UDATA2, FORM_SDATA2: size = 2;
      FORM_UDATA4, FORM_SDATA4: size = 4;
      FORM_UDATA8, FORM_SDATA8: size = 8;
      FORM_ULEB, FORM_SLEB: size = 0;
      default: begin
        close_field('0, dec_seen + 1, 1'b1);
        return;
      end
    endcase
    if (size != 0) begin
      if (dec_shift < 64) dec_acc |= {56'h0, bt.data_byte} << dec_shift;
      dec_shift = (dec_shift + 8 > 127) ? 127 : dec_shift + 8;
      dec_seen++;
      if (dec_seen < size) return;
      v = dec_acc;
      if (form == FORM_SDATA2 && v[15]) v |= ~64'hFFFF;
      else if (form == FORM_SDATA4 && v[31]) v |= ~64'hFFFF_FFFF;
    end else begin
      if (dec_shift < 64) dec_acc |= {57'h0, bt.data_byte[6:0]} << dec_shift;
      dec_shift = (dec_shift + 7 > 127) ? 127 : dec_shift + 7;
      dec_seen++;
      if (bt.data_byte[7]) begin
        if (dec_seen >= MAX_LEB_BYTES) close_field('0, MAX_LEB_BYTES, 1'b1);
        return;
      end
      v = dec_acc;
      if (form == FORM_SLEB && dec_shift < 64 && bt.data_byte[6]) v |= ~64'h0 << dec_shift;
    end
    if (dec_encoding[6:4] == APP_PCREL) v += dec_base;
    close_field(v, dec_seen, 1'b0);
  endtask

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // result check and input beat capture
  always @(posedge clk) begin
    field_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_dwarf_eh_pointer_decoder: FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        if (expected_fields.size() == 0) begin
          $error("unexpected result beat: value %h count %0d error %b",
                 out_tdata[63:0], out_tdata[68:64], out_tuser);
          fail_count++;
        end else begin
          want = expected_fields.pop_front();
          if (out_tdata[63:0] !== want.value) begin
            $error("decoded_value: expected %h, got %h", want.value, out_tdata[63:0]);
            fail_count++;
          end
          if (out_tdata[68:64] !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, out_tdata[68:64]);
            fail_count++;
          end
          if (out_tuser !== want.err) begin
            $error("decode_error: expected %b, got %b", want.err, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        decode_byte(current_beat);
      end
    end
  end

  // input driver and result backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          current_beat = pending_bytes.pop_front();
          in_tdata  <= {current_beat.field_address, current_beat.data_byte};
          in_tuser  <= current_beat.field_start;
          in_tvalid <= 1'b1;
          if (send_stretch == 0) begin
            send_stretch = $urandom_range(16, 96);
            send_calm = ($urandom_range(0, 2) == 0);
          end
          send_stretch--;
          send_gap = draw_wait(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (out_taken) begin
        out_taken = 1'b0;
        if (recv_stretch == 0) begin
          recv_stretch = $urandom_range(8, 48);
          recv_calm = ($urandom_range(0, 2) == 0);
        end
        recv_stretch--;
        recv_stall = draw_wait(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(logic [7:0] b, logic start, logic [63:0] addr);
    byte_beat_t bt;
    bt.data_byte     = b;
    bt.field_start   = start;
    bt.field_address = addr;
    pending_bytes.insert(pending_bytes.size(), bt);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_fields.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_encoding(logic [7:0] enc);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enc;
    dec_encoding = enc;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] random_data();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] random_address();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] random_encoding();
    logic [3:0] valid_forms [9];
    int r;
    int u;
    logic [3:0] form;
    logic [2:0] app;
    valid_forms = '{FORM_ABSPTR, FORM_ULEB, FORM_UDATA2, FORM_UDATA4, FORM_UDATA8,
                    FORM_SLEB, FORM_SDATA2, FORM_SDATA4, FORM_SDATA8};
    r = $urandom_range(0, 11);
    if (r == 0) return ENC_OMIT;
    if (r == 1) return {4'h0, FORM_ABSPTR};
    if (r == 2) begin
      u = $urandom_range(0, 6);
      form = (u < 4) ? 4'(5 + u) : 4'(9 + u);
      return {4'($urandom_range(0, 15)), form};
    end
    form = valid_forms[$urandom_range(0, 8)];
    app = ($urandom_range(0, 1) == 0) ? APP_PCREL : 3'($urandom_range(0, 7));
    return {1'($urandom_range(0, 1)), app, form};
  endfunction

  // one field under the current encoding, cut short when truncate is set
  task automatic queue_field(bit truncate, output int n);
    logic [7:0]  b;
    logic [63:0] addr;
    logic [3:0]  form;
    int full;
    int r;
    bit leb;
    bit overlong;
    form = dec_encoding[3:0];
    leb = 1'b0;
    overlong = 1'b0;
    case (form)
      FORM_ABSPTR: full = POINTER_BYTES;
      FORM_UDATA2, FORM_SDATA2: full = 2;
      FORM_UDATA4, FORM_SDATA4: full = 4;
      FORM_UDATA8, FORM_SDATA8: full = 8;
      FORM_ULEB, FORM_SLEB: begin
        leb = 1'b1;
        r = $urandom_range(0, 9);
        if (r < 6) full = $urandom_range(1, 3);
        else if (r < 9) full = $urandom_range(4, MAX_LEB_BYTES);
        else begin
          full = MAX_LEB_BYTES;
          overlong = 1'b1;
        end
      end
      default: full = 1;
    endcase
    if (dec_encoding == ENC_OMIT) full = 1;
    n = (truncate && full > 1) ? $urandom_range(1, full - 1) : full;
    addr = random_address();
    for (int i = 0; i < n; i++) begin
      b = random_data();
      if (leb) b[7] = overlong || (i < full - 1);
      queue_byte(b, i == 0, addr);
    end
  endtask

  initial begin
    int field_bytes;
    int n;
    int r;
    field_bytes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_encoding({4'h0, FORM_ABSPTR});
    for (int i = 0; i < POINTER_BYTES; i++) queue_byte(8'hFF, i == 0, '1);

    set_encoding({4'h0, FORM_SLEB});
    queue_byte(8'h40, 1'b1, '0);
    queue_byte(8'h7F, 1'b1, '1);

    set_encoding({1'b0, APP_PCREL, FORM_SDATA4});
    queue_byte(8'h00, 1'b1, 64'h1000);
    queue_byte(8'h00, 1'b0, '0);
    queue_byte(8'h00, 1'b0, '0);
    queue_byte(8'h80, 1'b0, '0);

    set_encoding(ENC_OMIT);
    queue_byte(8'hA5, 1'b1, '1);

    // reserved form, then a stray beat with no open field
    set_encoding({4'h0, FORM_RESERVED});
    queue_byte(8'h5A, 1'b1, 64'h55);
    queue_byte(8'h33, 1'b0, 64'h77);

    // restart while a field is open
    set_encoding({1'b0, APP_PCREL, FORM_UDATA2});
    queue_byte(8'h11, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_byte(8'h22, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_byte(8'h33, 1'b0, '0);

    set_encoding({4'h0, FORM_ULEB});
    queue_byte(8'h80, 1'b1, '0);
    queue_byte(8'h00, 1'b0, '0);
    queue_byte(8'h81, 1'b1, '0);

    // encoding switched while the leb field above is still open
    set_encoding({4'h0, FORM_UDATA2});
    queue_byte(8'hC3, 1'b0, '0);

    while (field_bytes < ITEM_TARGET) begin
      set_encoding(random_encoding());
      repeat ($urandom_range(4, 16)) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          queue_byte(random_data(), 1'b0, random_address());
        end else begin
          queue_field(r == 1, n);
          field_bytes += n;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_dwarf_eh_pointer_decoder: PASS");
    end else begin
      $display("tb_dwarf_eh_pointer_decoder: FAIL");
    end
    $finish;
  end

endmodule
